[hw/rtl/reorder_receiver_cumulative_ack_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the reorder receiver
// Concurrent assertion wrappers used by rrca_back.
// ----------------------------------------------------------------------------
`ifndef REORDER_RECEIVER_CUMULATIVE_ACK_MACROS_SVH
`define REORDER_RECEIVER_CUMULATIVE_ACK_MACROS_SVH

// check prop on every clock edge outside reset
`define RRCA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop on every clock edge, reset included
`define RRCA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rrca_pkg.sv]
// ----------------------------------------------------------------------------
// rrca_pkg
// Shared types and constants of the reorder receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rrca_pkg;

  localparam int WINDOW_DEF   = 32;
  localparam int MAX_PAYLOAD  = 1024;
  localparam int SEQ_BITS     = 32;
  localparam int TAG_BITS     = 16;

  localparam int SEQ_FIELD_W  = 32;
  localparam int LEN_W        = 11;
  localparam int TAG_FIELD_W  = 16;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 64;
  localparam int OUT_USER_W   = 3;
  localparam int QDEPTH       = 2;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_ACK     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq;
    logic [LEN_W-1:0]    len;
    logic [TAG_BITS-1:0] tag;
    logic                oversize;
  } seg_item_t;

  typedef struct packed {
    kind_t               kind;
    logic [SEQ_BITS-1:0] seq;
    logic [LEN_W-1:0]    len;
    logic [TAG_BITS-1:0] tag;
    logic                closing;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/rrca_front.sv]
// ----------------------------------------------------------------------------
// rrca_front
// Accepts segments, unpacks and screens them, and queues them for the
// back end in a short FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module rrca_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rrca_pkg::IN_DATA_W-1:0] in_tdata,
  output rrca_pkg::seg_item_t                 q_item,
  output logic                                q_valid,
  input  wire logic                           q_pop
);
  import rrca_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  seg_item_t            ent_r [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  seg_item_t            new_item;
  logic                 push;

  always_comb begin
    new_item.seq      = in_tdata[SEQ_BITS-1:0];
    new_item.len      = in_tdata[SEQ_FIELD_W +: LEN_W];
    new_item.tag      = in_tdata[SEQ_FIELD_W + LEN_W +: TAG_BITS];
    new_item.oversize = (new_item.len > LEN_W'(MAX_PAYLOAD));
  end

  assign in_tready = (cnt_r != CNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop && q_valid})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rrca_back.sv]
// ----------------------------------------------------------------------------
// rrca_back
// Keeps the expected sequence and the reorder slots, runs delivery,
// ack and release, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reorder_receiver_cumulative_ack_macros.svh"

module rrca_back #(
  parameter int WINDOW = rrca_pkg::WINDOW_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  rrca_pkg::seg_item_t      q_item,
  input  wire logic                q_valid,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rrca_pkg::result_t        out_res
);
  import rrca_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_REL  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [SEQ_BITS-1:0] exp_r, exp_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic                closed_r, closed_nxt;
  logic [WINDOW-1:0]   vld_r, vld_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             res_r, res_nxt;
  logic [SEQ_BITS-1:0] rel_seq_r, rel_seq_nxt;
  logic [TAG_BITS-1:0] rel_tag_r, rel_tag_nxt;

  logic [TAG_BITS-1:0] mem_tag [WINDOW];
  logic [LEN_W-1:0]    mem_len [WINDOW];
  logic [TAG_BITS-1:0] rd_tag_r;
  logic [LEN_W-1:0]    rd_len_r;

  logic                slot_free;
  logic [SEQ_BITS-1:0] seq_gap;
  logic                in_win;
  logic [IDX_W:0]      idx_sum;
  logic [IDX_W-1:0]    hold_idx;
  logic [IDX_W-1:0]    head_inc;
  logic                wr_en;
  logic                closed_c;

  assign slot_free = !out_valid_r || out_ready;
  assign seq_gap   = q_item.seq - exp_r;
  assign in_win    = (seq_gap < SEQ_BITS'(WINDOW));
  assign idx_sum   = (IDX_W + 1)'(head_r) + (IDX_W + 1)'(seq_gap[IDX_W-1:0]);
  assign hold_idx  = (idx_sum >= (IDX_W + 1)'(WINDOW)) ?
                     IDX_W'(idx_sum - (IDX_W + 1)'(WINDOW)) : IDX_W'(idx_sum);
  assign head_inc  = (head_r == IDX_W'(WINDOW - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    head_nxt      = head_r;
    closed_nxt    = closed_r;
    vld_nxt       = vld_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    rel_seq_nxt   = rel_seq_r;
    rel_tag_nxt   = rel_tag_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    closed_c      = closed_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          if (closed_r || q_item.oversize) begin
            res_nxt = '{KIND_RELEASE, q_item.seq, '0, q_item.tag, closed_r, 1'b1};
          end else if (seq_gap == '0) begin
            closed_c         = closed_r || (q_item.len == '0);
            closed_nxt       = closed_c;
            res_nxt          = '{KIND_DELIVER, q_item.seq, q_item.len, q_item.tag,
                                 closed_c, 1'b0};
            vld_nxt[head_r]  = 1'b0;
            exp_nxt          = exp_r + 1'b1;
            head_nxt         = head_inc;
            cnt_nxt          = CNT_W'(1);
            state_nxt        = ST_RUN;
          end else begin
            res_nxt = '{KIND_ACK, exp_r, '0, '0, closed_r, 1'b0};
            if (in_win && !vld_r[hold_idx]) begin
              res_nxt.last      = 1'b1;
              wr_en             = 1'b1;
              vld_nxt[hold_idx] = 1'b1;
            end else begin
              rel_seq_nxt = q_item.seq;
              rel_tag_nxt = q_item.tag;
              state_nxt   = ST_REL;
            end
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (vld_r[head_r] && (cnt_r < CNT_W'(WINDOW))) begin
            closed_c        = closed_r || (rd_len_r == '0);
            closed_nxt      = closed_c;
            res_nxt         = '{KIND_DELIVER, exp_r, rd_len_r, rd_tag_r, closed_c, 1'b0};
            vld_nxt[head_r] = 1'b0;
            exp_nxt         = exp_r + 1'b1;
            head_nxt        = head_inc;
            cnt_nxt         = cnt_r + 1'b1;
          end else begin
            res_nxt   = '{KIND_ACK, exp_r, '0, '0, closed_r, 1'b1};
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{KIND_RELEASE, rel_seq_r, '0, rel_tag_r, closed_r, 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_r       <= '0;
      head_r      <= '0;
      closed_r    <= 1'b0;
      vld_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      head_r      <= head_nxt;
      closed_r    <= closed_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    rel_seq_r <= rel_seq_nxt;
    rel_tag_r <= rel_tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_tag[hold_idx] <= q_item.tag;
      mem_len[hold_idx] <= q_item.len;
    end
    rd_tag_r <= mem_tag[head_nxt];
    rd_len_r <= mem_len[head_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `RRCA_ASSERT(a_hold_not_head, clk, rst_n, (wr_en |-> hold_idx != head_r), "hold targets head slot")
  `RRCA_ASSERT(a_closed_sticky, clk, rst_n, (closed_r |=> closed_r), "close flag cleared")
  `RRCA_ASSERT(a_deliver_not_last, clk, rst_n, (out_valid_r && res_r.kind == KIND_DELIVER |-> !res_r.last), "deliver marked last")
  `RRCA_ASSERT(a_run_bound, clk, rst_n, (cnt_r <= CNT_W'(WINDOW)), "delivery run too long")
  `RRCA_ASSERT_NR(a_reset_idle, clk, (!rst_n |=> !out_valid_r && state_r == ST_IDLE), "not idle after reset")

endmodule

`default_nettype wire

[hw/rtl/reorder_receiver_cumulative_ack.sv]
// ----------------------------------------------------------------------------
// reorder_receiver_cumulative_ack
// Sliding-window segment receiver with reorder slots and cumulative acks.
//
// Input channel in_*: one received segment per item (sequence, length, tag).
// Output channel out_*: deliver, release and ack items; tlast marks the
// final result of a segment. A segment queues in a two-entry FIFO, so the
// input keeps accepting while results wait on the output.
// First result: with the queue empty and the back end idle, an accepted
// segment is written into the queue, then popped into the result register.
// Throughput: the back end emits one result per cycle unless the output
// stalls; a segment yields 1 result if held or screened, 2 for an
// out-of-order drop, k+2 for an in-order segment releasing k held slots.
// The rate is set by the delivery walk, which reads one slot per cycle while the output does not stall.
// Reset: expected sequence zero, all slots empty, not closed, queue empty.
// Output stall: the result register holds; the back end waits, the queue
// fills, and then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module reorder_receiver_cumulative_ack #(
  parameter int WINDOW = rrca_pkg::WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // seg_seq[31:0], payload_len[42:32], buf_tag[58:43], zero fill
  input  wire logic [rrca_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_seq[31:0], out_len[42:32], out_tag[58:43], zero fill
  output logic [rrca_pkg::OUT_DATA_W-1:0]      out_tdata,
  // kind[1:0], closing[2]
  output logic [rrca_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast
);
  import rrca_pkg::*;

  seg_item_t q_item;
  logic      q_valid;
  logic      q_pop;
  result_t   res;

  rrca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  rrca_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {
    (OUT_DATA_W - SEQ_FIELD_W - LEN_W - TAG_FIELD_W)'(0),
    TAG_FIELD_W'(res.tag),
    res.len,
    SEQ_FIELD_W'(res.seq)
  };
  assign out_tuser = {res.closing, res.kind};
  assign out_tlast = res.last;

endmodule

`default_nettype wire
